>>> design/gradient_preview_pixel_assert.svh
// Assertion macros for the gradient preview pixel top level.
`ifndef GRADIENT_PREVIEW_PIXEL_ASSERT_SVH
`define GRADIENT_PREVIEW_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define GPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GPP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GPP_ASSERT_IMP(label, clk, rst, ante, cons)
`define GPP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/gpp_pkg.sv
// Types and constants of the gradient preview pixel block.
package gpp_pkg;
   localparam int POSITION_BITS = 10;
   localparam int ALPHA_BITS    = 10;

   localparam logic [1:0] OP_LOAD_COLOUR = 2'd0;
   localparam logic [1:0] OP_LOAD_ALPHA  = 2'd1;
   localparam logic [1:0] OP_RENDER      = 2'd2;
   localparam logic [1:0] KIND_BLACK     = 2'd0;
   localparam logic [1:0] KIND_WHITE     = 2'd1;
   localparam logic [1:0] CSR_SPAN_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_SINGLE_COLOUR = 2'd1;
   localparam logic [1:0] CSR_COLOUR_COUNT  = 2'd2;
   localparam logic [1:0] CSR_ALPHA_COUNT   = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [4:0]  stop_index;
      logic [10:0] stop_position;
      logic [1:0]  colour_kind;
      logic [7:0]  stop_red;
      logic [7:0]  stop_green;
      logic [7:0]  stop_blue;
      logic [10:0] stop_alpha;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic        row_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } rsp_type;

   // Divider control: start with operands, done with quotient.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage

>>> design/gpp_divider.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
module gpp_divider
   import gpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] shifted;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff[15:0], quot_ff[31]};
      trial    = shifted - {1'b0, dsr_ff};
      if (div_req.start) begin
         quot_in  = div_req.dividend;
         rem_in   = '0;
         dsr_in   = div_req.divisor;
         count_in = 6'd32;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in  = trial;
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[30:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;
endmodule

>>> design/gradient_preview_pixel.sv
// Top level of the gradient preview pixel block: stop tables and render sequencer.
//
// Channel   Direction  Handshake                 Payload
// req_      in         start high, busy low      req_type
// rsp_      out        rsp_valid strobe          rsp_type
// csr_      in         csr_valid and csr_ready   csr_index, csr_data
//
// A load transfer is written into its table at the accepting edge and busy stays low. A render
// item keeps busy high through the cursor walk and up to five divisions, which run one after
// another on the shared serial divider. Reset clears the cursors and restores the configuration
// defaults; the tables stay undefined until written. The receiver cannot stall, so each result is
// shown in the last busy cycle and the next item can be accepted in the cycle after it.
module gradient_preview_pixel
   import gpp_pkg::*;
#(
   parameter int MAX_STOPS = 32
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
`include "gradient_preview_pixel_assert.svh"
   localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CW = IW + 1;
   localparam logic [11:0] FULL = 12'(1 << POSITION_BITS);
   localparam logic [11:0] AFULL = 12'(1 << ALPHA_BITS);

   typedef enum logic [3:0] {
      S_IDLE, S_POS_START, S_POS_WAIT, S_WALK_C, S_WALK_A, S_FETCH,
      S_LERP_START, S_LERP_WAIT, S_BLEND, S_OUT
   } state_type;

   // tables
   logic [36:0] ctab [MAX_STOPS];
   logic [21:0] atab [MAX_STOPS];
   logic [36:0] crd_ff;
   logic [21:0] ard_ff;
   logic [IW-1:0] craddr, araddr;

   logic [12:0] span_ff;
   logic        single_ff;
   logic [5:0]  ccount_ff, acount_ff;

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [IW-1:0] ccur_ff, ccur_in, acur_ff, acur_in;
   logic [11:0] pos_ff, pos_in;
   logic [1:0]  step_ff, step_in;    // 0 fetch left, 1 left valid, 2 right valid
   logic [36:0] cl_ff, cl_in, cr_ff, cr_in;
   logic [21:0] al_ff, al_in, ar_ff, ar_in;
   logic [1:0]  lane_ff, lane_in;    // 0..2 colour, 3 alpha
   logic        neg_ff, neg_in;
   logic [11:0] lerp_ff [4];
   logic [11:0] lerp_in [4];
   logic [7:0]  out_ff [3];
   logic [7:0]  out_in [3];
   logic        rv_ff, rv_in;
   logic        busy_ff, busy_in;

   div_req_type dreq;
   div_rsp_type drsp;

   gpp_divider u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));

   logic accept;
   assign accept = start && !busy_ff;
   assign busy = busy_ff;
   assign csr_ready = 1'b1;

   // clamped stop counts and last segment index
   logic [CW-1:0] cc, ac, clast, alast;
   always_comb begin
      cc = (ccount_ff < 6'd2) ? CW'(2)
         : (32'(ccount_ff) > 32'(MAX_STOPS)) ? CW'(MAX_STOPS) : CW'(ccount_ff);
      ac = (acount_ff < 6'd2) ? CW'(2)
         : (32'(acount_ff) > 32'(MAX_STOPS)) ? CW'(MAX_STOPS) : CW'(acount_ff);
      clast = cc - CW'(2);
      alast = ac - CW'(2);
   end

   function automatic logic [7:0] chan(input logic [36:0] s, input logic [1:0] k);
      logic [7:0] v;
      if (s[36:35] == KIND_BLACK) v = 8'd0;
      else if (s[36:35] == KIND_WHITE) v = 8'd255;
      else v = (k == 2'd0) ? s[23:16] : (k == 2'd1) ? s[15:8] : s[7:0];
      return v;
   endfunction

   // lerp operands for current lane
   logic [11:0] lv, rv, lp, rp;
   logic [12:0] dnum, dspan;
   logic [13:0] dval;
   logic [13:0] dmag;
   logic        dneg;
   logic [26:0] prod;
   always_comb begin
      if (lane_ff == 2'd3) begin
         lv = {1'b0, al_ff[10:0]};
         rv = {1'b0, ar_ff[10:0]};
         lp = (acur_ff == '0) ? 12'd0 : {1'b0, al_ff[21:11]};
         rp = {1'b0, ar_ff[21:11]};
      end else begin
         lv = {4'd0, chan(cl_ff, lane_ff)};
         rv = {4'd0, chan(cr_ff, lane_ff)};
         lp = {1'b0, cl_ff[34:24]};
         rp = {1'b0, cr_ff[34:24]};
      end
      dval  = {2'b0, rv} - {2'b0, lv};
      dneg  = dval[13] ^ ($signed({1'b0, pos_ff}) < $signed({1'b0, lp}))
            ^ ($signed({1'b0, rp}) < $signed({1'b0, lp}));
      dnum  = ($signed({1'b0, pos_ff}) < $signed({1'b0, lp})) ? 13'(lp - pos_ff)
            : 13'(pos_ff - lp);
      dspan = (rp < lp) ? 13'(lp - rp) : 13'(rp - lp);
      dmag  = dval[13] ? 14'(-dval) : dval;
      prod  = 27'(dmag) * 27'(dnum);
   end

   // signed result of lerp with clamping
   logic signed [33:0] lres;
   logic [11:0] lclamp;
   always_comb begin
      lres = neg_ff ? -$signed({2'b0, drsp.quotient}) : $signed({2'b0, drsp.quotient});
      lres = lres + $signed({22'd0, lv});
      if (lres < 0) lclamp = 12'd0;
      else if (lane_ff == 2'd3) lclamp = (lres > $signed({22'd0, AFULL})) ? AFULL : 12'(lres);
      else lclamp = (lres > 34'sd255) ? 12'd255 : 12'(lres);
   end

   // blend
   logic phase;
   logic [7:0] bg [3];
   logic signed [9:0] diff [3];
   logic signed [23:0] bprod [3];
   logic signed [23:0] bsum [3];
   always_comb begin
      phase = req_ff.pixel_x[2] ^ req_ff.pixel_y[2];
      bg[0] = 8'hff;
      bg[1] = phase ? 8'hc8 : 8'he8;
      bg[2] = phase ? 8'hce : 8'heb;
      for (int i = 0; i < 3; i++) begin
         diff[i]  = $signed({2'b0, lerp_ff[i][7:0]}) - $signed({2'b0, bg[i]});
         bprod[i] = 24'(diff[i]) * 24'($signed({1'b0, lerp_ff[3]}));
         bsum[i]  = (bprod[i] >>> ALPHA_BITS) + $signed({16'd0, bg[i]});
      end
   end

   always_comb begin
      state_in = state_ff;
      ccur_in  = ccur_ff;
      acur_in  = acur_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      cl_in = cl_ff; cr_in = cr_ff; al_in = al_ff; ar_in = ar_ff;
      lane_in  = lane_ff;
      neg_in   = neg_ff;
      lerp_in  = lerp_ff;
      out_in   = out_ff;
      rv_in    = 1'b0;
      busy_in  = busy_ff;
      dreq     = '0;
      craddr   = ccur_ff;
      araddr   = acur_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_payload.opcode == OP_RENDER) begin
                  busy_in  = 1'b1;
                  state_in = S_POS_START;
               end
            end
         end
         S_POS_START: begin
            dreq.start    = 1'b1;
            dreq.dividend = 32'(req_ff.pixel_x) << POSITION_BITS;
            dreq.divisor  = (span_ff < 13'd2) ? 16'd1 : 16'(span_ff - 13'd1);
            if (req_ff.row_start) begin
               ccur_in = '0;
               acur_in = '0;
            end else begin
               if (CW'(ccur_ff) > clast) ccur_in = IW'(clast);
               if (CW'(acur_ff) > alast) acur_in = IW'(alast);
            end
            state_in = S_POS_WAIT;
         end
         S_POS_WAIT: begin
            if (drsp.done) begin
               pos_in   = (drsp.quotient > 32'(FULL)) ? FULL : 12'(drsp.quotient);
               step_in  = 2'd0;
               state_in = S_WALK_C;
            end
         end
         S_WALK_C: begin
            craddr = IW'(ccur_ff + IW'(1));
            if (step_ff == 2'd0) begin
               if (CW'(ccur_ff) >= clast) state_in = S_WALK_A;
               else step_in = 2'd1;
            end else begin
               step_in = 2'd0;
               if (pos_ff > {1'b0, crd_ff[34:24]}) ccur_in = ccur_ff + IW'(1);
               else state_in = S_WALK_A;
            end
         end
         S_WALK_A: begin
            araddr = IW'(acur_ff + IW'(1));
            if (step_ff == 2'd0) begin
               if (CW'(acur_ff) >= alast) begin
                  state_in = S_FETCH;
               end else step_in = 2'd1;
            end else begin
               step_in = 2'd0;
               if (pos_ff > {1'b0, ard_ff[21:11]}) acur_in = acur_ff + IW'(1);
               else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            // step 0 reads left, step 1 reads right, step 2 latches right
            if (step_ff == 2'd0) begin
               craddr = ccur_ff; araddr = acur_ff;
               step_in = 2'd1;
            end else if (step_ff == 2'd1) begin
               craddr = IW'(ccur_ff + IW'(1)); araddr = IW'(acur_ff + IW'(1));
               cl_in = crd_ff; al_in = ard_ff;
               step_in = 2'd2;
            end else begin
               cr_in = crd_ff; ar_in = ard_ff;
               step_in = 2'd0;
               lane_in = single_ff ? 2'd3 : 2'd0;
               if (single_ff)
                  for (int i = 0; i < 3; i++) lerp_in[i] = {4'd0, chan(cl_ff, 2'(i))};
               state_in = S_LERP_START;
            end
         end
         S_LERP_START: begin
            if (dspan == 13'd0) begin
               lerp_in[lane_ff] = (lane_ff == 2'd3 && lv > AFULL) ? AFULL : lv;
               if (lane_ff == 2'd3) state_in = S_BLEND;
               else lane_in = lane_ff + 2'd1;
            end else begin
               dreq.start    = 1'b1;
               dreq.dividend = 32'(prod);
               dreq.divisor  = 16'(dspan);
               neg_in        = dneg && (prod != '0);
               state_in      = S_LERP_WAIT;
            end
         end
         S_LERP_WAIT: begin
            if (drsp.done) begin
               lerp_in[lane_ff] = lclamp;
               if (lane_ff == 2'd3) state_in = S_BLEND;
               else begin
                  lane_in  = lane_ff + 2'd1;
                  state_in = S_LERP_START;
               end
            end
         end
         S_BLEND: begin
            for (int i = 0; i < 3; i++)
               out_in[i] = (bsum[i] < 0) ? 8'd0 : (bsum[i] > 24'sd255) ? 8'd255 : 8'(bsum[i]);
            rv_in    = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      crd_ff <= ctab[craddr];
      ard_ff <= atab[araddr];
      if (accept && req_payload.opcode == OP_LOAD_COLOUR && 32'(req_payload.stop_index) < MAX_STOPS)
         ctab[IW'(req_payload.stop_index)] <= {req_payload.colour_kind, req_payload.stop_position,
            req_payload.stop_red, req_payload.stop_green, req_payload.stop_blue};
      if (accept && req_payload.opcode == OP_LOAD_ALPHA && 32'(req_payload.stop_index) < MAX_STOPS)
         atab[IW'(req_payload.stop_index)] <= {req_payload.stop_position, req_payload.stop_alpha};
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_payload;
      pos_ff <= pos_in;
      step_ff <= step_in;
      cl_ff <= cl_in; cr_ff <= cr_in; al_ff <= al_in; ar_ff <= ar_in;
      lane_ff <= lane_in;
      neg_ff <= neg_in;
      lerp_ff <= lerp_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         ccur_ff   <= '0;
         acur_ff   <= '0;
         rv_ff     <= 1'b0;
         busy_ff   <= 1'b0;
         span_ff   <= 13'd256;
         single_ff <= 1'b0;
         ccount_ff <= 6'd2;
         acount_ff <= 6'd2;
      end else begin
         state_ff <= state_in;
         ccur_ff  <= ccur_in;
         acur_ff  <= acur_in;
         rv_ff    <= rv_in;
         busy_ff  <= busy_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SPAN_WIDTH:    span_ff   <= csr_data;
               CSR_SINGLE_COLOUR: single_ff <= csr_data[0];
               CSR_COLOUR_COUNT:  ccount_ff <= csr_data[5:0];
               CSR_ALPHA_COUNT:   acount_ff <= csr_data[5:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_payload.out_red   = out_ff[0];
   assign rsp_payload.out_green = out_ff[1];
   assign rsp_payload.out_blue  = out_ff[2];

   `GPP_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `GPP_ASSERT_NXT(a_rsp_one, clock, reset, rsp_valid, !rsp_valid)
   `GPP_ASSERT_IMP(a_cur_range, clock, reset, state_ff == S_FETCH, CW'(ccur_ff) <= clast)
   `GPP_ASSERT_NXT(a_busy_drop, clock, reset, rsp_valid, !busy)
endmodule
